@@ rtl/sgd_pkg.sv @@
// Shared types, widths and helper functions for the segment distance pipeline.
package sgd_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DIST_BITS  = 33;

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int QUOT_BITS  = SUM_BITS + 2 * FRAC_BITS;
   localparam int ROOT_BITS  = (QUOT_BITS + 1) / 2;
   localparam int MAG_LO     = SUM_BITS / 2;
   localparam int MAG_HI     = SUM_BITS - MAG_LO;

   localparam int PS_LAT     = 6 + QUOT_BITS;
   localparam int PIPE_LAST  = PS_LAT + 2 + ROOT_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef enum logic [1:0] {
      ORI_ZERO,
      ORI_POS,
      ORI_NEG
   } orient_type;

   function automatic diff_type diff_of(coord_type q, coord_type p);
      return DIFF_BITS'(q) - DIFF_BITS'(p);
   endfunction

   function automatic orient_type orient_of(logic signed [SUM_BITS-1:0] v);
      if (v == '0) begin
         return ORI_ZERO;
      end else if (v < 0) begin
         return ORI_NEG;
      end
      return ORI_POS;
   endfunction

endpackage

@@ rtl/sgd_point_seg.sv @@
// Pipelined squared point-to-segment distance, scaled and divided to an integer quotient.
module sgd_point_seg (
   input  logic                          clock,
   input  logic                          advance,
   input  sgd_pkg::point_type            pnt,
   input  sgd_pkg::point_type            seg_a,
   input  sgd_pkg::point_type            seg_b,
   output logic [sgd_pkg::QUOT_BITS-1:0] quot
);
   import sgd_pkg::*;

   diff_type dx_ff, dy_ff, wx_ff, wy_ff, ex_ff, ey_ff;

   logic signed [PROD_BITS-1:0] wxdx_ff, wydy_ff, wxdy_ff, wydx_ff;
   logic signed [PROD_BITS-1:0] wxwx_ff, wywy_ff, exex_ff, eyey_ff, dxdx_ff, dydy_ff;

   logic signed [SUM_BITS-1:0] dot_ff, cr_ff, wl_ff, el_ff, dd_ff;

   logic                  inner4_ff;
   logic [SUM_BITS-1:0]   crm_ff, nend4_ff, dd4_ff;
   logic                  near_a_in, near_b_in;

   logic                      inner5_ff;
   logic [SUM_BITS-1:0]       nend5_ff, dd5_ff;
   logic [2*MAG_HI-1:0]       hh_ff;
   logic [MAG_HI+MAG_LO-1:0]  hl_ff;
   logic [2*MAG_LO-1:0]       ll_ff;

   logic [2*SUM_BITS-1:0] cr2_in, nm_in;

   logic [SUM_BITS-1:0]  rem_ff [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] sh_ff  [QUOT_BITS+1];
   logic [SUM_BITS-1:0]  den_ff [QUOT_BITS+1];
   logic [SUM_BITS-1:0]  rem_in [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] sh_in  [QUOT_BITS+1];
   logic [SUM_BITS:0]    trial  [QUOT_BITS+1];
   logic                 take   [QUOT_BITS+1];

   always_comb begin
      near_a_in = (dot_ff <= 0);
      near_b_in = !near_a_in && (dot_ff >= dd_ff);
      cr2_in = ((2*SUM_BITS)'(hh_ff) << (2*MAG_LO))
             + ((2*SUM_BITS)'(hl_ff) << (MAG_LO+1))
             + (2*SUM_BITS)'(ll_ff);
      nm_in = inner5_ff ? cr2_in : (2*SUM_BITS)'(nend5_ff);
   end

   always_comb begin
      rem_in[0] = '0;
      sh_in[0]  = '0;
      trial[0]  = '0;
      take[0]   = 1'b0;
      for (int k = 1; k <= QUOT_BITS; k++) begin
         trial[k]  = {rem_ff[k-1], sh_ff[k-1][QUOT_BITS-1]};
         take[k]   = (trial[k] >= {1'b0, den_ff[k-1]});
         rem_in[k] = take[k] ? SUM_BITS'(trial[k] - {1'b0, den_ff[k-1]})
                             : trial[k][SUM_BITS-1:0];
         sh_in[k]  = {sh_ff[k-1][QUOT_BITS-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= diff_of(seg_b.x, seg_a.x);
         dy_ff <= diff_of(seg_b.y, seg_a.y);
         wx_ff <= diff_of(pnt.x, seg_a.x);
         wy_ff <= diff_of(pnt.y, seg_a.y);
         ex_ff <= diff_of(pnt.x, seg_b.x);
         ey_ff <= diff_of(pnt.y, seg_b.y);

         wxdx_ff <= wx_ff * dx_ff;
         wydy_ff <= wy_ff * dy_ff;
         wxdy_ff <= wx_ff * dy_ff;
         wydx_ff <= wy_ff * dx_ff;
         wxwx_ff <= wx_ff * wx_ff;
         wywy_ff <= wy_ff * wy_ff;
         exex_ff <= ex_ff * ex_ff;
         eyey_ff <= ey_ff * ey_ff;
         dxdx_ff <= dx_ff * dx_ff;
         dydy_ff <= dy_ff * dy_ff;

         dot_ff <= SUM_BITS'(wxdx_ff) + SUM_BITS'(wydy_ff);
         cr_ff  <= SUM_BITS'(wxdy_ff) - SUM_BITS'(wydx_ff);
         wl_ff  <= SUM_BITS'(wxwx_ff) + SUM_BITS'(wywy_ff);
         el_ff  <= SUM_BITS'(exex_ff) + SUM_BITS'(eyey_ff);
         dd_ff  <= SUM_BITS'(dxdx_ff) + SUM_BITS'(dydy_ff);

         inner4_ff <= !near_a_in && !near_b_in;
         crm_ff    <= cr_ff[SUM_BITS-1] ? $unsigned(-cr_ff) : $unsigned(cr_ff);
         nend4_ff  <= near_a_in ? $unsigned(wl_ff) : $unsigned(el_ff);
         dd4_ff    <= $unsigned(dd_ff);

         inner5_ff <= inner4_ff;
         nend5_ff  <= nend4_ff;
         dd5_ff    <= dd4_ff;
         hh_ff     <= crm_ff[SUM_BITS-1:MAG_LO] * crm_ff[SUM_BITS-1:MAG_LO];
         hl_ff     <= crm_ff[SUM_BITS-1:MAG_LO] * crm_ff[MAG_LO-1:0];
         ll_ff     <= crm_ff[MAG_LO-1:0] * crm_ff[MAG_LO-1:0];

         rem_ff[0] <= nm_in[2*SUM_BITS-1:SUM_BITS];
         sh_ff[0]  <= QUOT_BITS'(nm_in[SUM_BITS-1:0]) << (2*FRAC_BITS);
         den_ff[0] <= inner5_ff ? dd5_ff : SUM_BITS'(1);

         for (int k = 1; k <= QUOT_BITS; k++) begin
            rem_ff[k] <= rem_in[k];
            sh_ff[k]  <= sh_in[k];
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quot = sh_ff[QUOT_BITS];

endmodule

@@ rtl/sgd_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
module sgd_isqrt (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [sgd_pkg::QUOT_BITS-1:0] value,
   output logic [sgd_pkg::ROOT_BITS-1:0] root
);
   import sgd_pkg::*;

   logic [ROOT_BITS+1:0]   rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]   root_ff [ROOT_BITS];
   logic [2*ROOT_BITS-1:0] val_ff  [ROOT_BITS];

   logic [ROOT_BITS+1:0]   rem_src  [ROOT_BITS];
   logic [ROOT_BITS-1:0]   root_src [ROOT_BITS];
   logic [2*ROOT_BITS-1:0] val_src  [ROOT_BITS];
   logic [ROOT_BITS+3:0]   acc      [ROOT_BITS];
   logic [ROOT_BITS+3:0]   trial    [ROOT_BITS];
   logic                   take     [ROOT_BITS];
   logic [ROOT_BITS+1:0]   rem_in   [ROOT_BITS];
   logic [ROOT_BITS-1:0]   root_in  [ROOT_BITS];
   logic [2*ROOT_BITS-1:0] val_in   [ROOT_BITS];

   always_comb begin
      for (int k = 0; k < ROOT_BITS; k++) begin
         if (k == 0) begin
            rem_src[k]  = '0;
            root_src[k] = '0;
            val_src[k]  = (2*ROOT_BITS)'(value);
         end else begin
            rem_src[k]  = rem_ff[k-1];
            root_src[k] = root_ff[k-1];
            val_src[k]  = val_ff[k-1];
         end
         acc[k]     = {rem_src[k], val_src[k][2*ROOT_BITS-1 -: 2]};
         trial[k]   = (ROOT_BITS+4)'({root_src[k], 2'b01});
         take[k]    = (acc[k] >= trial[k]);
         rem_in[k]  = take[k] ? (ROOT_BITS+2)'(acc[k] - trial[k])
                              : acc[k][ROOT_BITS+1:0];
         root_in[k] = {root_src[k][ROOT_BITS-2:0], take[k]};
         val_in[k]  = val_src[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            val_ff[k]  <= val_in[k];
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

@@ rtl/segment_segment_distance_unit.sv @@
// Top level of the segment-to-segment distance pipeline.
//
// The request channel carries two 2D segments as eight signed coordinates;
// a transfer happens on a rising edge where req_valid is high and req_stall
// is low. The response channel returns one result per request, in order:
// rsp_distance is the least distance in unsigned fixed point with 16
// fraction bits, floored, and rsp_intersects is set when the segments touch
// or cross, with the distance then zero.
// Every stage takes a new pair in every cycle unless the pipeline holds, so
// throughput is one pair per cycle while responses are not stalled. A result
// reaches the response register after passing the 67 quotient stages of the
// four parallel dividers and the 34 root stages of the square root unit.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty and ready right after.
module segment_segment_distance_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sgd_pkg::coord_type            req_first_start_x,
   input  sgd_pkg::coord_type            req_first_start_y,
   input  sgd_pkg::coord_type            req_first_end_x,
   input  sgd_pkg::coord_type            req_first_end_y,
   input  sgd_pkg::coord_type            req_second_start_x,
   input  sgd_pkg::coord_type            req_second_start_y,
   input  sgd_pkg::coord_type            req_second_end_x,
   input  sgd_pkg::coord_type            req_second_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sgd_pkg::DIST_BITS-1:0] rsp_distance,
   output logic                          rsp_intersects
);
   import sgd_pkg::*;

   localparam int HIT_LEN = PIPE_LAST - 2;

   logic adv;

   logic vld_ff [PIPE_LAST+1];
   logic hit_ff [HIT_LEN];

   point_type pt_ff [4];

   diff_type                    od_ff [12];
   logic                        box1_ff [4];
   logic                        box2_ff [4];
   logic signed [PROD_BITS-1:0] oa_ff [4];
   logic signed [PROD_BITS-1:0] ob_ff [4];

   orient_type ori_in [4];
   logic       hit_in;

   logic [QUOT_BITS-1:0] quot [4];
   logic [QUOT_BITS-1:0] m1_ff [2];
   logic [QUOT_BITS-1:0] m2_ff;
   logic [ROOT_BITS-1:0] root;

   logic                 rsp_valid_ff;
   logic [DIST_BITS-1:0] rsp_distance_ff;
   logic                 rsp_intersects_ff;
   logic [DIST_BITS-1:0] rsp_distance_in;

   function automatic logic between(coord_type a, coord_type q, coord_type b);
      return ((q >= a) && (q <= b)) || ((q >= b) && (q <= a));
   endfunction

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ori_in[i] = orient_of(SUM_BITS'(oa_ff[i]) - SUM_BITS'(ob_ff[i]));
      end
      hit_in = ((ori_in[0] != ori_in[1]) && (ori_in[2] != ori_in[3]))
            || ((ori_in[0] == ORI_ZERO) && box2_ff[0])
            || ((ori_in[1] == ORI_ZERO) && box2_ff[1])
            || ((ori_in[2] == ORI_ZERO) && box2_ff[2])
            || ((ori_in[3] == ORI_ZERO) && box2_ff[3]);
   end

   always_comb begin
      if (hit_ff[HIT_LEN-1]) begin
         rsp_distance_in = '0;
      end else if (|root[ROOT_BITS-1:DIST_BITS]) begin
         rsp_distance_in = '1;
      end else begin
         rsp_distance_in = root[DIST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= PIPE_LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= PIPE_LAST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[PIPE_LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff[0] <= '{x: req_first_start_x, y: req_first_start_y};
         pt_ff[1] <= '{x: req_first_end_x, y: req_first_end_y};
         pt_ff[2] <= '{x: req_second_start_x, y: req_second_start_y};
         pt_ff[3] <= '{x: req_second_end_x, y: req_second_end_y};

         od_ff[0]  <= diff_of(pt_ff[1].x, pt_ff[0].x);
         od_ff[1]  <= diff_of(pt_ff[1].y, pt_ff[0].y);
         od_ff[2]  <= diff_of(pt_ff[2].x, pt_ff[1].x);
         od_ff[3]  <= diff_of(pt_ff[2].y, pt_ff[1].y);
         od_ff[4]  <= diff_of(pt_ff[3].x, pt_ff[1].x);
         od_ff[5]  <= diff_of(pt_ff[3].y, pt_ff[1].y);
         od_ff[6]  <= diff_of(pt_ff[3].x, pt_ff[2].x);
         od_ff[7]  <= diff_of(pt_ff[3].y, pt_ff[2].y);
         od_ff[8]  <= diff_of(pt_ff[0].x, pt_ff[3].x);
         od_ff[9]  <= diff_of(pt_ff[0].y, pt_ff[3].y);
         od_ff[10] <= diff_of(pt_ff[1].x, pt_ff[3].x);
         od_ff[11] <= diff_of(pt_ff[1].y, pt_ff[3].y);

         box1_ff[0] <= between(pt_ff[0].x, pt_ff[2].x, pt_ff[1].x)
                    && between(pt_ff[0].y, pt_ff[2].y, pt_ff[1].y);
         box1_ff[1] <= between(pt_ff[0].x, pt_ff[3].x, pt_ff[1].x)
                    && between(pt_ff[0].y, pt_ff[3].y, pt_ff[1].y);
         box1_ff[2] <= between(pt_ff[2].x, pt_ff[0].x, pt_ff[3].x)
                    && between(pt_ff[2].y, pt_ff[0].y, pt_ff[3].y);
         box1_ff[3] <= between(pt_ff[2].x, pt_ff[1].x, pt_ff[3].x)
                    && between(pt_ff[2].y, pt_ff[1].y, pt_ff[3].y);

         oa_ff[0] <= od_ff[1] * od_ff[2];
         ob_ff[0] <= od_ff[0] * od_ff[3];
         oa_ff[1] <= od_ff[1] * od_ff[4];
         ob_ff[1] <= od_ff[0] * od_ff[5];
         oa_ff[2] <= od_ff[7] * od_ff[8];
         ob_ff[2] <= od_ff[6] * od_ff[9];
         oa_ff[3] <= od_ff[7] * od_ff[10];
         ob_ff[3] <= od_ff[6] * od_ff[11];
         for (int i = 0; i < 4; i++) begin
            box2_ff[i] <= box1_ff[i];
         end

         hit_ff[0] <= hit_in;
         for (int j = 1; j < HIT_LEN; j++) begin
            hit_ff[j] <= hit_ff[j-1];
         end

         m1_ff[0] <= (quot[1] < quot[0]) ? quot[1] : quot[0];
         m1_ff[1] <= (quot[3] < quot[2]) ? quot[3] : quot[2];
         m2_ff    <= (m1_ff[1] < m1_ff[0]) ? m1_ff[1] : m1_ff[0];

         rsp_distance_ff   <= rsp_distance_in;
         rsp_intersects_ff <= hit_ff[HIT_LEN-1];
      end
   end

   sgd_point_seg u_ps_a (
      .clock(clock), .advance(adv), .pnt(pt_ff[0]), .seg_a(pt_ff[2]), .seg_b(pt_ff[3]),
      .quot(quot[0])
   );
   sgd_point_seg u_ps_b (
      .clock(clock), .advance(adv), .pnt(pt_ff[1]), .seg_a(pt_ff[2]), .seg_b(pt_ff[3]),
      .quot(quot[1])
   );
   sgd_point_seg u_ps_c (
      .clock(clock), .advance(adv), .pnt(pt_ff[2]), .seg_a(pt_ff[0]), .seg_b(pt_ff[1]),
      .quot(quot[2])
   );
   sgd_point_seg u_ps_d (
      .clock(clock), .advance(adv), .pnt(pt_ff[3]), .seg_a(pt_ff[0]), .seg_b(pt_ff[1]),
      .quot(quot[3])
   );

   sgd_isqrt u_isqrt (
      .clock(clock), .advance(adv), .value(m2_ff), .root(root)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = rsp_distance_ff;
   assign rsp_intersects = rsp_intersects_ff;

   // A transfer that touches or crosses always reports a zero distance.
   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_intersects_ff |-> rsp_distance_ff == '0)
      else $error("intersecting result with nonzero distance");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // A finished item in the last stage moves into the response register.
   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[PIPE_LAST] |=> rsp_valid_ff)
      else $error("finished item lost at the output");

endmodule
